// File: rtl/core/mbrtu_pkg.sv
// Shared types, constants and the CRC-16 step for the Modbus RTU slave register bank.
// Depends on nothing; the engine, the top level and the testbench import it.
`default_nettype none
package mbrtu_pkg;

   // Payload of one received request byte.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_item_type;

   // Payload of one response byte.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_item_type;

   // Function codes served.
   localparam logic [7:0] FC_READ_REGS   = 8'h03;
   localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

   localparam logic [7:0]  STATION_RESET = 8'h01;
   localparam int          MAX_READ_QTY  = 8;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;

   localparam int NUM_REGS_DEFAULT    = 8;
   localparam int FRAME_BYTES_DEFAULT = 256;

   // One byte of the reflected Modbus CRC-16.
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/mbrtu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module mbrtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire                                        clock,
   input  wire                                        we,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire [WIDTH-1:0]                            wdata,
   input  wire                                        re,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: rtl/core/mbrtu_engine.sv
// Frame store, register bank and the sequencer that checks and serves one frame.
// Depends on mbrtu_pkg and mbrtu_ram.
`default_nettype none
module mbrtu_engine #(
   parameter int NUM_REGS    = 8,
   parameter int FRAME_BYTES = 256
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire [7:0]                  station,
   input  wire                        in_valid,
   input  mbrtu_pkg::req_item_type    in_item,
   output logic                       in_ready,
   output logic                       out_valid,
   output mbrtu_pkg::rsp_item_type    out_item,
   input  wire                        out_take
);
   import mbrtu_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES + 1);
   localparam int AW = $clog2(FRAME_BYTES);
   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int QW = $clog2(NUM_REGS + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN_A = 4'd1;
   localparam logic [3:0] ST_SCAN_D = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_WR_HA  = 4'd4;
   localparam logic [3:0] ST_WR_HD  = 4'd5;
   localparam logic [3:0] ST_WR_LA  = 4'd6;
   localparam logic [3:0] ST_WR_LD  = 4'd7;
   localparam logic [3:0] ST_RD_A   = 4'd8;
   localparam logic [3:0] ST_RD_D   = 4'd9;
   localparam logic [3:0] ST_SEND   = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                ovr_ff, ovr_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          hdr_ff [6];
   logic [7:0]          hdr_in [6];
   logic [7:0]          rxlo_ff, rxlo_in, rxhi_ff, rxhi_in;
   logic                is_read_ff, is_read_in;
   logic [QW-1:0]       j_ff, j_in;
   logic [4:0]          k_ff, k_in, len_ff, len_in;
   logic [7:0]          whi_ff, whi_in;
   logic [15:0]         word_ff, word_in;
   logic [RW-1:0]       rd_addr_ff, rd_addr_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [NUM_REGS-1:0] vld_ff, vld_in;

   // Memory ports.
   logic          f_we, f_re;
   logic [AW-1:0] f_waddr, f_raddr;
   logic [7:0]    f_rdata;
   logic          b_we, b_re;
   logic [RW-1:0] b_waddr, b_raddr;
   logic [15:0]   b_wdata, b_rdata;

   // Decoded request fields and checks.
   logic [15:0]   start_w, qty_w;
   logic [16:0]   end_w;
   logic [17:0]   need_w;
   logic [CW-1:0] body_w;
   logic          base_ok, rd_ok, w1_ok, wm_ok;
   logic [7:0]    tx_w;
   logic [4:0]    nxt_k;
   logic [CW-1:0] wr_off;

   mbrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(in_item.rx_byte),
      .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
   );

   mbrtu_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_bank (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
      .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
   );

   assign start_w = {hdr_ff[2], hdr_ff[3]};
   assign qty_w   = {hdr_ff[4], hdr_ff[5]};
   assign end_w   = {1'b0, start_w} + {1'b0, qty_w};
   assign need_w  = 18'd7 + {1'b0, qty_w, 1'b0};
   assign body_w  = n_ff - CW'(2);

   // Request checks evaluated once the whole frame has been scanned.
   always_comb begin
      base_ok = (crc_ff == {rxhi_ff, rxlo_ff}) && (hdr_ff[0] == station)
                && (body_w >= CW'(6));
      rd_ok = base_ok && (hdr_ff[1] == FC_READ_REGS) && (qty_w != 16'd0)
              && (qty_w <= 16'(MAX_READ_QTY)) && (end_w <= 17'(NUM_REGS));
      w1_ok = base_ok && (hdr_ff[1] == FC_WRITE_ONE) && (start_w < 16'(NUM_REGS));
      wm_ok = base_ok && (hdr_ff[1] == FC_WRITE_MULTI) && (qty_w != 16'd0)
              && (end_w <= 17'(NUM_REGS)) && (need_w <= 18'(body_w));
   end

   // Reply byte selected by position.
   always_comb begin
      if (k_ff == len_ff) begin
         tx_w = crc_ff[7:0];
      end else if (k_ff == len_ff + 5'd1) begin
         tx_w = crc_ff[15:8];
      end else if (is_read_ff) begin
         case (k_ff)
            5'd0:    tx_w = hdr_ff[0];
            5'd1:    tx_w = FC_READ_REGS;
            5'd2:    tx_w = {qty_w[6:0], 1'b0};
            default: tx_w = k_ff[0] ? word_ff[15:8] : word_ff[7:0];
         endcase
      end else begin
         case (k_ff)
            5'd0:    tx_w = hdr_ff[0];
            5'd1:    tx_w = hdr_ff[1];
            5'd2:    tx_w = hdr_ff[2];
            5'd3:    tx_w = hdr_ff[3];
            5'd4:    tx_w = hdr_ff[4];
            default: tx_w = hdr_ff[5];
         endcase
      end
   end

   assign nxt_k  = k_ff + 5'd1;
   assign wr_off = CW'(7) + CW'({j_ff, 1'b0});

   assign in_ready         = (state_ff == ST_IDLE);
   assign out_valid        = (state_ff == ST_SEND);
   assign out_item.tx_byte = tx_w;
   assign out_item.tx_last = (k_ff == len_ff + 5'd1);

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovr_in     = ovr_ff;
      n_in       = n_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      hdr_in     = hdr_ff;
      rxlo_in    = rxlo_ff;
      rxhi_in    = rxhi_ff;
      is_read_in = is_read_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      len_in     = len_ff;
      whi_in     = whi_ff;
      word_in    = word_ff;
      rd_addr_in = rd_addr_ff;
      rd_vld_in  = rd_vld_ff;
      vld_in     = vld_ff;
      f_we       = 1'b0;
      f_waddr    = cnt_ff[AW-1:0];
      f_re       = 1'b0;
      f_raddr    = idx_ff[AW-1:0];
      b_we       = 1'b0;
      b_waddr    = start_w[RW-1:0];
      b_wdata    = qty_w;
      b_re       = 1'b0;
      b_raddr    = start_w[RW-1:0] + RW'(j_ff);
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               f_we = (cnt_ff < CW'(FRAME_BYTES));
               if (in_item.frame_end) begin
                  n_in   = f_we ? cnt_ff + CW'(1) : cnt_ff;
                  cnt_in = '0;
                  ovr_in = 1'b0;
                  idx_in = '0;
                  crc_in = CRC_INIT;
                  if (!(ovr_ff || !f_we) && (n_in >= CW'(2))) begin
                     state_in = ST_SCAN_A;
                  end
               end else if (f_we) begin
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  ovr_in = 1'b1;
               end
            end
         end
         ST_SCAN_A: begin
            f_re     = 1'b1;
            state_in = ST_SCAN_D;
         end
         ST_SCAN_D: begin
            if (idx_ff < n_ff - CW'(2)) begin
               crc_in = crc_update(crc_ff, f_rdata);
            end
            if (idx_ff < CW'(6)) begin
               hdr_in[idx_ff[2:0]] = f_rdata;
            end
            if (idx_ff == n_ff - CW'(2)) begin
               rxlo_in = f_rdata;
            end
            if (idx_ff == n_ff - CW'(1)) begin
               rxhi_in  = f_rdata;
               state_in = ST_CHECK;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SCAN_A;
            end
         end
         ST_CHECK: begin
            crc_in     = CRC_INIT;
            k_in       = '0;
            j_in       = '0;
            is_read_in = rd_ok;
            len_in     = rd_ok ? 5'd3 + {qty_w[3:0], 1'b0} : 5'd6;
            state_in   = ST_IDLE;
            if (rd_ok) begin
               state_in = ST_SEND;
            end else if (w1_ok) begin
               b_we                     = 1'b1;
               vld_in[start_w[RW-1:0]] = 1'b1;
               state_in                 = ST_SEND;
            end else if (wm_ok) begin
               state_in = ST_WR_HA;
            end
         end
         ST_WR_HA: begin
            f_re     = 1'b1;
            f_raddr  = wr_off[AW-1:0];
            state_in = ST_WR_HD;
         end
         ST_WR_HD: begin
            whi_in   = f_rdata;
            state_in = ST_WR_LA;
         end
         ST_WR_LA: begin
            f_re     = 1'b1;
            f_raddr  = wr_off[AW-1:0] + AW'(1);
            state_in = ST_WR_LD;
         end
         ST_WR_LD: begin
            b_we            = 1'b1;
            b_waddr         = start_w[RW-1:0] + RW'(j_ff);
            b_wdata         = {whi_ff, f_rdata};
            vld_in[b_waddr] = 1'b1;
            j_in            = j_ff + QW'(1);
            state_in        = (QW'(j_ff + QW'(1)) == qty_w[QW-1:0]) ? ST_SEND : ST_WR_HA;
         end
         ST_RD_A: begin
            b_re       = 1'b1;
            rd_addr_in = b_raddr;
            rd_vld_in  = vld_ff[b_raddr];
            state_in   = ST_RD_D;
         end
         ST_RD_D: begin
            word_in  = rd_vld_ff ? b_rdata : 16'(rd_addr_ff) + 16'd1;
            j_in     = j_ff + QW'(1);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_take) begin
               if (k_ff < len_ff) begin
                  crc_in = crc_update(crc_ff, tx_w);
               end
               k_in = nxt_k;
               if (out_item.tx_last) begin
                  state_in = ST_IDLE;
               end else if (is_read_ff && nxt_k >= 5'd3 && nxt_k < len_ff && nxt_k[0]) begin
                  state_in = ST_RD_A;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovr_ff   <= 1'b0;
         vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovr_ff   <= ovr_in;
         vld_ff   <= vld_in;
      end
   end

   // Working registers of the frame being served.
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      idx_ff     <= idx_in;
      crc_ff     <= crc_in;
      hdr_ff     <= hdr_in;
      rxlo_ff    <= rxlo_in;
      rxhi_ff    <= rxhi_in;
      is_read_ff <= is_read_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      len_ff     <= len_in;
      whi_ff     <= whi_in;
      word_ff    <= word_in;
      rd_addr_ff <= rd_addr_in;
      rd_vld_ff  <= rd_vld_in;
   end
endmodule
`default_nettype wire

// File: rtl/core/modbus_rtu_slave_register_bank_unit.sv
// Top level of the Modbus RTU slave register bank: station register, output register
// and the frame engine. Depends on mbrtu_pkg, mbrtu_engine and mbrtu_ram.
//
// Usage: request bytes enter on the req_ channel, one transfer per byte, with
// frame_end set on the last byte of a frame. A byte that does not end a frame
// is stored while the engine is idle. At frame end the engine reads the
// stored frame back through the frame store read port, an address state and a
// data state per byte, then checks it; req_ready stays low until the reply is
// fully sent or the frame is dropped. Reply bytes leave on the rsp_ channel
// through an output register, one byte per cycle while rsp_ready is high; a read
// reply also pauses at each register for the bank's read port. A stalled receiver
// simply holds the current byte and pauses the engine. The station address is
// written on the csr_ channel, which is always ready. Reset sets the station
// address to 1, empties the output register, clears the frame counter, and makes
// every bank register read as its index plus one until written.
`default_nettype none
module modbus_rtu_slave_register_bank_unit #(
   parameter int NUM_REGS    = mbrtu_pkg::NUM_REGS_DEFAULT,
   parameter int FRAME_BYTES = mbrtu_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  mbrtu_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output mbrtu_pkg::rsp_item_type rsp_item,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [7:0]               csr_data
);
   import mbrtu_pkg::*;

   logic [7:0]   station_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         eng_valid, eng_take;
   rsp_item_type eng_item;

   mbrtu_engine #(.NUM_REGS(NUM_REGS), .FRAME_BYTES(FRAME_BYTES)) u_engine (
      .clock(clock), .reset(reset), .station(station_ff),
      .in_valid(req_valid), .in_item(req_item), .in_ready(req_ready),
      .out_valid(eng_valid), .out_item(eng_item), .out_take(eng_take)
   );

   // The engine hands over a byte whenever the output register is free or draining.
   assign eng_take = eng_valid && (!rsp_valid_ff || rsp_ready);

   // Station address register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= STATION_RESET;
      end else if (csr_valid) begin
         station_ff <= csr_data;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_take) begin
         rsp_item_ff <= eng_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the Modbus RTU slave register bank unit.
// Depends on mbrtu_pkg and modbus_rtu_slave_register_bank_unit; sends request
// frames byte by byte and checks every reply byte against a local bank model.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbrtu_pkg::*;

   localparam int BANK_REGS   = 8;
   localparam int STORE_BYTES = 256;
   localparam int DRAIN_CYCLES = 800;
   localparam int HOLD_CYCLES  = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = 8'h00;

   // Model of the slave: station address, bank, frame store and counters.
   logic [7:0]  station;
   logic [15:0] bank [BANK_REGS];
   logic [7:0]  store [STORE_BYTES];
   int          store_count;
   logic        store_overrun;

   rsp_item_type reply_q [$];
   logic [7:0]   frame_q [$];
   int errors = 0;
   bit no_idle = 0;
   bit hold_off = 0;
   int sent_bytes = 0;

   modbus_rtu_slave_register_bank_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("FAIL modbus_rtu_slave_register_bank_unit");
      $finish;
   end

   // One byte of the reflected CRC-16 with polynomial 0xA001.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   // Queues one reply, CRC appended low byte first.
   task automatic queue_reply(input logic [7:0] buf8 [32], input int len);
      logic [15:0] crc;
      rsp_item_type it;
      crc = 16'hFFFF;
      for (int i = 0; i < len; i++) crc = crc_step(crc, buf8[i]);
      buf8[len] = crc[7:0];
      buf8[len + 1] = crc[15:8];
      for (int i = 0; i < len + 2; i++) begin
         it.tx_byte = buf8[i];
         it.tx_last = (i == len + 1);
         reply_q.push_back(it);
      end
   endtask

   // Decides the reply, if any, to the frame now held in the store.
   task automatic serve_stored_frame();
      logic [7:0]  rep [32];
      logic [15:0] crc, got;
      int body, start, qty;
      if (store_overrun || store_count < 2) return;
      body = store_count - 2;
      got = {store[store_count - 1], store[store_count - 2]};
      crc = 16'hFFFF;
      for (int i = 0; i < body; i++) crc = crc_step(crc, store[i]);
      if (crc != got) return;
      if (body < 1 || store[0] != station) return;
      if (body < 6) return;
      start = int'({store[2], store[3]});
      qty = int'({store[4], store[5]});
      for (int i = 0; i < 6; i++) rep[i] = store[i];
      case (store[1])
         FC_READ_REGS: begin
            if (qty == 0 || qty > MAX_READ_QTY || start + qty > BANK_REGS) return;
            rep[0] = station;
            rep[2] = 8'(qty * 2);
            for (int i = 0; i < qty; i++) begin
               rep[3 + 2 * i] = bank[start + i][15:8];
               rep[4 + 2 * i] = bank[start + i][7:0];
            end
            queue_reply(rep, 3 + 2 * qty);
         end
         FC_WRITE_ONE: begin
            if (start >= BANK_REGS) return;
            bank[start] = 16'(qty);
            queue_reply(rep, 6);
         end
         FC_WRITE_MULTI: begin
            if (qty == 0 || start + qty > BANK_REGS || 7 + 2 * qty > body) return;
            for (int i = 0; i < qty; i++) bank[start + i] = {store[7 + 2 * i], store[8 + 2 * i]};
            queue_reply(rep, 6);
         end
         default: ;
      endcase
   endtask

   // Updates the model with one accepted request byte.
   task automatic model_byte(input logic [7:0] b, input logic last);
      if (store_count < STORE_BYTES) begin
         store[store_count] = b;
         store_count++;
      end else begin
         store_overrun = 1'b1;
      end
      if (last) begin
         serve_stored_frame();
         store_count = 0;
         store_overrun = 1'b0;
      end
   endtask

   // Offers one request byte after a random gap and waits for its transfer.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_item_type it;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.rx_byte = b;
      it.frame_end = last;
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
      sent_bytes++;
      model_byte(b, last);
   endtask

   // Sends the queued frame, then drops valid and clears the queue.
   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
      req_valid <= 1'b0;
      @(posedge clock);
      frame_q.delete();
   endtask

   task automatic add_crc();
      logic [15:0] crc;
      crc = 16'hFFFF;
      foreach (frame_q[i]) crc = crc_step(crc, frame_q[i]);
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
   endtask

   // Builds address, function and two 16-bit fields; data for writes is added by the caller.
   task automatic build_req(input logic [7:0] addr, input logic [7:0] fc,
                            input logic [15:0] a, input logic [15:0] b);
      frame_q.delete();
      frame_q.push_back(addr);
      frame_q.push_back(fc);
      frame_q.push_back(a[15:8]);
      frame_q.push_back(a[7:0]);
      frame_q.push_back(b[15:8]);
      frame_q.push_back(b[7:0]);
   endtask

   task automatic do_read(input logic [15:0] start, input logic [15:0] qty);
      build_req(station, FC_READ_REGS, start, qty);
      add_crc();
      send_frame();
   endtask

   task automatic do_write_one(input logic [15:0] idx, input logic [15:0] val);
      build_req(station, FC_WRITE_ONE, idx, val);
      add_crc();
      send_frame();
   endtask

   task automatic do_write_multi(input logic [15:0] start, input logic [15:0] qty,
                                 input int words);
      build_req(station, FC_WRITE_MULTI, start, qty);
      frame_q.push_back(8'(2 * qty));
      repeat (2 * words) frame_q.push_back(8'($urandom_range(0, 255)));
      add_crc();
      send_frame();
   endtask

   // Waits until every expected reply byte arrived and the engine settled.
   task automatic wait_idle();
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_station(input logic [7:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      station = v;
   endtask

   // Receiver: random stalls, an optional long hold-off, and the reply check.
   initial begin
      int gap;
      rsp_item_type want;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (reply_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected reply byte %h last %b",
                                       rsp_item.tx_byte, rsp_item.tx_last);
         end else begin
            want = reply_q.pop_front();
            if (want.tx_byte != rsp_item.tx_byte || want.tx_last != rsp_item.tx_last) begin
               errors++;
               if (errors <= 10) $display("reply mismatch: expected %h/%b actual %h/%b",
                                          want.tx_byte, want.tx_last,
                                          rsp_item.tx_byte, rsp_item.tx_last);
            end
         end
      end
   end

   // Reads and writes across the whole bank, including the value extremes.
   task automatic test_registers();
      do_read(16'd0, 16'd8);
      do_write_one(16'd0, 16'hFFFF);
      do_write_one(16'd7, 16'h0000);
      do_write_multi(16'd0, 16'd8, 8);
      do_read(16'd0, 16'd8);
   endtask

   // Drop rules of the slave, each in one frame.
   task automatic test_drops();
      frame_q.push_back(8'hA5);
      send_frame();                           // single byte frame
      build_req(station, FC_READ_REGS, 16'd0, 16'd1);
      add_crc();
      frame_q[7] = frame_q[7] ^ 8'h01;        // corrupted CRC
      send_frame();
      build_req(station + 8'd1, FC_READ_REGS, 16'd0, 16'd1);
      add_crc();
      send_frame();                           // another station
      build_req(station, 8'h42, 16'd0, 16'd1);
      add_crc();
      send_frame();                           // unknown function
      frame_q.push_back(station);
      frame_q.push_back(FC_WRITE_ONE);
      frame_q.push_back(8'h00);
      add_crc();
      send_frame();                           // too short for its function
      do_read(16'd6, 16'd3);                  // past the bank
      do_write_one(16'd8, 16'h1234);
      do_read(16'd0, 16'd0);                  // zero quantity
      do_write_multi(16'd0, 16'd0, 0);
      do_read(16'd0, 16'd9);                  // read reply too long
      do_write_multi(16'd0, 16'd2, 1);        // data runs past the frame
      // Store overrun: a well-formed read padded to one byte beyond the store.
      build_req(station, FC_READ_REGS, 16'd0, 16'd1);
      repeat (STORE_BYTES - 7) frame_q.push_back(8'($urandom_range(0, 255)));
      add_crc();
      send_frame();
      do_read(16'd0, 16'd2);
   endtask

   // Random frames: mostly well-formed requests, the rest broken or noise.
   task automatic rand_frame();
      int kind, n;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: do_read(16'($urandom_range(0, 7)), 16'($urandom_range(1, 8)));
         3, 4:    do_write_one(16'($urandom_range(0, 8)), 16'($urandom));
         5, 6: begin
            n = $urandom_range(1, 8);
            do_write_multi(16'($urandom_range(0, 8 - n)), 16'(n), n);
         end
         7: begin
            build_req(($urandom_range(0, 3) == 0) ? 8'($urandom) : station,
                      8'($urandom), 16'($urandom_range(0, 9)), 16'($urandom_range(0, 9)));
            add_crc();
            if ($urandom_range(0, 1)) frame_q[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
            send_frame();
         end
         default: begin
            n = $urandom_range(1, 12);
            repeat (n) frame_q.push_back(8'($urandom));
            send_frame();
         end
      endcase
   endtask

   // Random frames until about the given number of bytes went out.
   task automatic test_random(input int budget);
      int first;
      first = sent_bytes;
      while (sent_bytes - first < budget) begin
         no_idle = ($urandom_range(0, 5) == 0);
         rand_frame();
      end
      no_idle = 0;
   endtask

   // Receiver holds off while reads keep coming, so the input must stall.
   task automatic test_backpressure();
      hold_off = 1;
      no_idle = 1;
      repeat (2) do_read(16'd0, 16'd8);
      no_idle = 0;
   endtask

   initial begin
      station = STATION_RESET;
      for (int k = 0; k < BANK_REGS; k++) bank[k] = 16'(k + 1);
      store_count = 0;
      store_overrun = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_drops();
      test_backpressure();
      test_random(30);
      write_station(8'h00);
      test_random(20);
      write_station(8'hFF);
      test_random(20);
      write_station(8'h5A);
      test_random(20);
      wait_idle();
      if (errors == 0) begin
         $display("PASS modbus_rtu_slave_register_bank_unit");
      end else begin
         $display("FAIL modbus_rtu_slave_register_bank_unit");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_ram.sv
rtl/core/mbrtu_engine.sv
rtl/core/modbus_rtu_slave_register_bank_unit.sv
test/tb.sv
